/* hw/rtl/morse_key_letter_decoder_core_macros.svh */
// Assertion macros for the Morse key letter decoder.
`ifndef MORSE_KEY_LETTER_DECODER_CORE_MACROS_SVH
`define MORSE_KEY_LETTER_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MKLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/mkld_pkg.sv */
package mkld_pkg;

    localparam int MAX_SIGNS_DEF     = 9;
    localparam int TABLE_ENTRIES_DEF = 5;
    localparam int MAX_TABLE         = 5;
    localparam int DEBOUNCE_MS       = 25;

    localparam int PRESS_W    = 12;
    localparam int GAP_W      = 16;
    localparam int ENTRY_W    = 21;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;
    localparam int PAT_W      = 9;
    localparam int LEN_LSB    = 8;
    localparam int PAT_LSB    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 3;

    localparam logic [PRESS_W-1:0] PRESS_SAT = '1;
    localparam logic [GAP_W-1:0]   GAP_SAT   = '1;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0  = 3'd3;

    localparam logic [PRESS_W-1:0] LONG_MIN_RESET = 12'd250;
    localparam logic [PRESS_W-1:0] LONG_MAX_RESET = 12'd1000;
    localparam logic [GAP_W-1:0]   GAP_RESET      = 16'd1000;

    typedef logic [ENTRY_W-1:0] entry_t;

    localparam entry_t ENTRY_RESET [MAX_TABLE] = '{
        21'd21603, 21'd617, 21'd8801, 21'd883, 21'd29551
    };

    typedef struct packed {
        logic [PRESS_W-1:0] long_min;
        logic [PRESS_W-1:0] long_max;
        logic [GAP_W-1:0]   gap;
    } timing_cfg_t;

    typedef struct packed {
        logic              found;
        logic [CHAR_W-1:0] letter_char;
    } match_t;

    typedef struct packed {
        logic              sign_valid;
        logic              sign_is_dash;
        logic [LEN_W-1:0]  sign_total;
        logic              letter_done;
        logic              letter_found;
        logic [CHAR_W-1:0] letter_char;
    } result_t;

endpackage

/* hw/rtl/mkld_cfg.sv */
module mkld_cfg #(
    parameter int TABLE_ENTRIES = mkld_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [mkld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkld_pkg::CFG_DATA_W-1:0] cfg_data,
    output mkld_pkg::timing_cfg_t           timing,
    output mkld_pkg::entry_t                entries [TABLE_ENTRIES]
);
    import mkld_pkg::*;

    timing_cfg_t timing_reg;
    entry_t      entry_reg [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.long_min <= LONG_MIN_RESET;
            timing_reg.long_max <= LONG_MAX_RESET;
            timing_reg.gap      <= GAP_RESET;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                entry_reg[k] <= ENTRY_RESET[k];
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LONG_MIN: timing_reg.long_min <= cfg_data[PRESS_W-1:0];
                REG_LONG_MAX: timing_reg.long_max <= cfg_data[PRESS_W-1:0];
                REG_GAP:      timing_reg.gap      <= cfg_data[GAP_W-1:0];
                default:      ;
            endcase
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (cfg_index == REG_ENTRY_0 + CFG_IDX_W'(k)) begin
                    entry_reg[k] <= cfg_data[ENTRY_W-1:0];
                end
            end
        end
    end

    assign timing  = timing_reg;
    assign entries = entry_reg;

endmodule

/* hw/rtl/mkld_match.sv */
module mkld_match #(
    parameter int MAX_SIGNS     = mkld_pkg::MAX_SIGNS_DEF,
    parameter int TABLE_ENTRIES = mkld_pkg::TABLE_ENTRIES_DEF,
    parameter int CNT_W         = $clog2(MAX_SIGNS + 1)
) (
    input  logic [MAX_SIGNS-1:0] sign_bits,
    input  logic [CNT_W-1:0]     sign_count,
    input  mkld_pkg::entry_t     entries [TABLE_ENTRIES],
    output mkld_pkg::match_t     hit
);
    import mkld_pkg::*;

    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int PE_W  = (MAX_SIGNS > PAT_W) ? MAX_SIGNS : PAT_W;

    logic [TABLE_ENTRIES-1:0] entry_hit;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         len_ext;
    logic [PE_W-1:0]          pat_ext;

    assign cnt_ext = CMP_W'(sign_count);

    // Pattern bits beyond the table's nine count as dots.
    always_comb begin
        len_ext = '0;
        pat_ext = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            len_ext      = CMP_W'(entries[k][LEN_LSB +: LEN_W]);
            pat_ext      = PE_W'(entries[k][PAT_LSB +: PAT_W]);
            entry_hit[k] = (len_ext == cnt_ext);
            for (int i = 0; i < MAX_SIGNS; i++) begin
                if ((sign_count > CNT_W'(i)) && (pat_ext[i] != sign_bits[i])) begin
                    entry_hit[k] = 1'b0;
                end
            end
        end
    end

    // The lowest-numbered matching entry wins.
    always_comb begin
        hit = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (entry_hit[k]) begin
                hit.found       = 1'b1;
                hit.letter_char = entries[k][CHAR_W-1:0];
            end
        end
    end

endmodule

/* hw/rtl/mkld_core.sv */
module mkld_core #(
    parameter int MAX_SIGNS     = mkld_pkg::MAX_SIGNS_DEF,
    parameter int TABLE_ENTRIES = mkld_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  key_down,
    input  mkld_pkg::timing_cfg_t timing,
    input  mkld_pkg::entry_t      entries [TABLE_ENTRIES],
    output mkld_pkg::result_t     result
);
    import mkld_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SIGNS + 1);
    localparam int CW_EXT = CNT_W + LEN_W;

    logic                 key_held_reg,   key_held_next;
    logic [PRESS_W-1:0]   press_reg,      press_next;
    logic [GAP_W-1:0]     gap_ticks_reg,  gap_ticks_next;
    logic                 gap_armed_reg,  gap_armed_next;
    logic [MAX_SIGNS-1:0] sign_bits_reg,  sign_bits_next;
    logic [CNT_W-1:0]     sign_count_reg, sign_count_next;

    logic              is_dot;
    logic              is_dash;
    logic              room;
    logic [GAP_W-1:0]  gap_inc;
    logic              gap_hit;
    logic [CW_EXT-1:0] count_ext;
    match_t            match;

    mkld_match #(
        .MAX_SIGNS     (MAX_SIGNS),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CNT_W         (CNT_W)
    ) u_match (
        .sign_bits  (sign_bits_reg),
        .sign_count (sign_count_reg),
        .entries    (entries),
        .hit        (match)
    );

    assign is_dot  = (press_reg > PRESS_W'(DEBOUNCE_MS)) && (press_reg < timing.long_min);
    assign is_dash = !is_dot && (press_reg >= timing.long_min)
                     && (press_reg < timing.long_max);
    assign room    = sign_count_reg < CNT_W'(MAX_SIGNS);
    assign gap_inc = (gap_ticks_reg != GAP_SAT) ? gap_ticks_reg + 16'd1 : gap_ticks_reg;
    assign gap_hit = gap_inc >= timing.gap;

    always_comb begin
        key_held_next   = key_held_reg;
        press_next      = press_reg;
        gap_ticks_next  = gap_ticks_reg;
        gap_armed_next  = gap_armed_reg;
        sign_bits_next  = sign_bits_reg;
        sign_count_next = sign_count_reg;
        result          = '0;

        if (key_down) begin
            if (!key_held_reg) begin
                press_next     = PRESS_W'(1);
                gap_armed_next = 1'b0;
                gap_ticks_next = '0;
            end else if (press_reg != PRESS_SAT) begin
                press_next = press_reg + PRESS_W'(1);
            end
            key_held_next = 1'b1;
        end else if (key_held_reg) begin
            if ((is_dot || is_dash) && room) begin
                for (int i = 0; i < MAX_SIGNS; i++) begin
                    if (is_dash && (sign_count_reg == CNT_W'(i))) begin
                        sign_bits_next[i] = 1'b1;
                    end
                end
                sign_count_next     = sign_count_reg + CNT_W'(1);
                result.sign_valid   = 1'b1;
                result.sign_is_dash = is_dash;
            end
            key_held_next  = 1'b0;
            gap_armed_next = 1'b1;
            gap_ticks_next = '0;
        end else if (gap_armed_reg) begin
            gap_ticks_next = gap_inc;
            if (gap_hit) begin
                result.letter_done  = 1'b1;
                result.letter_found = match.found;
                result.letter_char  = match.letter_char;
                sign_bits_next      = '0;
                sign_count_next     = '0;
                gap_armed_next      = 1'b0;
                gap_ticks_next      = '0;
            end
        end

        count_ext         = CW_EXT'(sign_count_next);
        result.sign_total = count_ext[LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_held_reg   <= 1'b0;
            press_reg      <= '0;
            gap_ticks_reg  <= '0;
            gap_armed_reg  <= 1'b0;
            sign_bits_reg  <= '0;
            sign_count_reg <= '0;
        end else if (step) begin
            key_held_reg   <= key_held_next;
            press_reg      <= press_next;
            gap_ticks_reg  <= gap_ticks_next;
            gap_armed_reg  <= gap_armed_next;
            sign_bits_reg  <= sign_bits_next;
            sign_count_reg <= sign_count_next;
        end
    end

endmodule

/* hw/rtl/morse_key_letter_decoder_core.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  one key sample per transfer
// m_        out        m_tvalid/m_tready  one result per accepted sample
// cfg_      in         cfg_valid/cfg_ready register write, always ready
//
// Each sample passes an input register and then a result register before
// its result appears; one sample is taken in every cycle unless m_tready
// stalls the output; the press and gap counters' update sets the rate.
// Synchronous active-low reset clears the counters and the pattern and
// restores the register defaults. When m_tready is low the result holds,
// one further sample waits in the input register, and then s_tready falls.

`include "morse_key_letter_decoder_core_macros.svh"

module morse_key_letter_decoder_core #(
    parameter int MAX_SIGNS     = mkld_pkg::MAX_SIGNS_DEF,
    parameter int TABLE_ENTRIES = mkld_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: key_down [0], zero [7:1]
    input  logic [mkld_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: sign_total [3:0], letter_char [11:4], zero [15:12]
    output logic [mkld_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tlast: letter_done
    output logic                            m_tlast,
    // m_tuser: sign_valid [0], sign_is_dash [1], letter_found [2]
    output logic [mkld_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mkld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkld_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mkld_pkg::*;

    timing_cfg_t timing;
    entry_t      entries [TABLE_ENTRIES];
    result_t     result;
    result_t     out_reg;
    logic        in_valid_reg;
    logic        in_key_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        step;

    mkld_cfg #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing),
        .entries   (entries)
    );

    mkld_core #(
        .MAX_SIGNS     (MAX_SIGNS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .key_down (in_key_reg),
        .timing   (timing),
        .entries  (entries),
        .result   (result)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg <= s_tdata[0];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.letter_char, out_reg.sign_total};
    assign m_tlast  = out_reg.letter_done;
    assign m_tuser  = {out_reg.letter_found, out_reg.sign_is_dash, out_reg.sign_valid};

    `MKLD_ASSERT_SAME(a_sign_not_letter, aclk, aresetn,
        m_tvalid && m_tuser[0], !m_tlast)
    `MKLD_ASSERT_SAME(a_found_needs_done, aclk, aresetn,
        m_tvalid && !m_tlast, (m_tuser[2] == 1'b0) && (m_tdata[11:4] == 8'd0))
    `MKLD_ASSERT_SAME(a_letter_clears_count, aclk, aresetn,
        m_tvalid && m_tlast, m_tdata[3:0] == 4'd0)
    `MKLD_ASSERT_NEXT(a_held_sample_kept, aclk, aresetn,
        in_valid_reg && !out_free, in_valid_reg && $stable(in_key_reg))

endmodule
